FILE: rtl/area_weighted_cdf_sampler_unit_assert.svh
// Assertion macros for the CDF sampler. Clock and reset names are fixed.
`ifndef AREA_WEIGHTED_CDF_SAMPLER_UNIT_ASSERT_SVH
`define AREA_WEIGHTED_CDF_SAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define AWCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AWCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/awcs_pkg.sv
`timescale 1ns / 1ps
package awcs_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int AREA_W          = 32;
  localparam int FRAC_W          = 32;
  localparam int PROB_W          = 33;
  localparam int ENTRY_IDX_W     = 10;
  localparam int DIV_STEPS       = 33;
  localparam int DCNT_W          = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_BUILD  = 2'd2,
    OP_SAMPLE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNBUILT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_SUM_RD,
    S_SUM_ACC,
    S_DIV_RD,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_PICK,
    S_PICK_OUT
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_SUM_RD,
    DP_SUM_ACC,
    DP_DIV_RD,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_WR,
    DP_SRCH_RD,
    DP_SRCH_CMP,
    DP_PICK,
    DP_PICK_OUT
  } dp_act_e;

  typedef struct packed {
    dp_act_e act;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic built;
    logic last;
    logic div_last;
    logic div_skip;
    logic found;
  } sts_t;

endpackage

FILE: rtl/area_weighted_cdf_sampler_unit.sv
`timescale 1ns / 1ps
// Area-weighted CDF sampler: append entries, build, then draw samples by
// inverting the CDF. One result per accepted beat; a new beat is taken only
// while the controller is idle. Build walks the table twice through the
// single area memory port: first it sums the areas, then it divides each
// area by the total in the one-bit-per-cycle restoring divider (excluded or
// zero-total entries skip it). Sample is a binary search over the CDF
// memory. No clearing pass after reset; the stores are only read where
// written.
module area_weighted_cdf_sampler_unit #(
  parameter int MAX_ENTRIES = awcs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       operation_i,
  input  logic [awcs_pkg::AREA_W-1:0]      area_i,
  input  logic                             excluded_i,
  input  logic [awcs_pkg::FRAC_W-1:0]      uniform_fraction_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [awcs_pkg::ENTRY_IDX_W-1:0] entry_index_o,
  output logic [awcs_pkg::PROB_W-1:0]      probability_o
);
  import awcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  awcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (operation_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  awcs_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .op_i               (operation_i),
    .area_i             (area_i),
    .excluded_i         (excluded_i),
    .uniform_fraction_i (uniform_fraction_i),
    .sts_o              (sts),
    .status_o           (status_o),
    .entry_index_o      (entry_index_o),
    .probability_o      (probability_o)
  );

`include "area_weighted_cdf_sampler_unit_assert.svh"

  `AWCS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "idle after accept")
  `AWCS_ASSERT_NOW(a_load_slot_free, cmd.load_out, !out_valid_o || !out_stall_i, "result overwritten")
  `AWCS_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid_o, "loaded result not shown")

endmodule

FILE: rtl/awcs_ctrl.sv
`timescale 1ns / 1ps
module awcs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     op_i,
  input  logic           out_stall_i,
  input  awcs_pkg::sts_t sts_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output awcs_pkg::cmd_t cmd_o
);
  import awcs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.act    = DP_NOP;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = DP_ACCEPT;
          case (op_e'(op_i))
            OP_BUILD:  state_d = sts_i.empty ? S_RESP : S_SUM_RD;
            OP_SAMPLE: state_d = (sts_i.empty || !sts_i.built) ? S_RESP : S_SRCH_RD;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_RESP: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SUM_RD: begin
        cmd_o.act = DP_SUM_RD;
        state_d   = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd_o.act = DP_SUM_ACC;
        state_d   = sts_i.last ? S_DIV_RD : S_SUM_RD;
      end
      S_DIV_RD: begin
        cmd_o.act = DP_DIV_RD;
        state_d   = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.act = DP_DIV_INIT;
        state_d   = sts_i.div_skip ? S_DIV_WR : S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd_o.act = DP_DIV_STEP;
        if (sts_i.div_last) state_d = S_DIV_WR;
      end
      S_DIV_WR: begin
        cmd_o.act = DP_DIV_WR;
        state_d   = sts_i.last ? S_RESP : S_DIV_RD;
      end
      S_SRCH_RD: begin
        cmd_o.act = DP_SRCH_RD;
        state_d   = sts_i.found ? S_PICK : S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        cmd_o.act = DP_SRCH_CMP;
        state_d   = S_SRCH_RD;
      end
      S_PICK: begin
        cmd_o.act = DP_PICK;
        state_d   = S_PICK_OUT;
      end
      S_PICK_OUT: begin
        cmd_o.act = DP_PICK_OUT;
        state_d   = S_RESP;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);

endmodule

FILE: rtl/awcs_dp.sv
`timescale 1ns / 1ps
module awcs_dp #(
  parameter int MAX_ENTRIES = awcs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  awcs_pkg::cmd_t                   cmd_i,
  input  logic [1:0]                       op_i,
  input  logic [awcs_pkg::AREA_W-1:0]      area_i,
  input  logic                             excluded_i,
  input  logic [awcs_pkg::FRAC_W-1:0]      uniform_fraction_i,
  output awcs_pkg::sts_t                   sts_o,
  output logic [1:0]                       status_o,
  output logic [awcs_pkg::ENTRY_IDX_W-1:0] entry_index_o,
  output logic [awcs_pkg::PROB_W-1:0]      probability_o
);
  import awcs_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int TW = AREA_W + AW;
  localparam int RW = TW + 1;

  logic [AREA_W:0]   area_mem [MAX_ENTRIES];
  logic [PROB_W-1:0] prob_mem [MAX_ENTRIES];
  logic [PROB_W-1:0] cdf_mem  [MAX_ENTRIES];   // entry i holds cdf[i+1]

  logic [AREA_W:0]   area_rd_q;
  logic [PROB_W-1:0] prob_rd_q, cdf_rd_q;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [TW-1:0]     total_q, total_d;
  logic              built_q, built_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [PROB_W-1:0] run_q, run_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [PROB_W-1:0] quo_q, quo_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [FRAC_W-1:0] u_q, u_d;
  logic [1:0]        res_st_q, res_st_d;
  logic [AW-1:0]     res_idx_q, res_idx_d;
  logic [PROB_W-1:0] res_prob_q, res_prob_d;
  logic [1:0]        out_st_q;
  logic [AW-1:0]     out_idx_q;
  logic [PROB_W-1:0] out_prob_q;

  logic              full, area_we, res_we;
  logic [CW:0]       mid_sum;
  logic [AW-1:0]     mid, pick;
  logic              ge;
  logic [RW-1:0]     rem_sub;
  logic [PROB_W-1:0] run_nx;

  assign full    = (cnt_q == CW'(MAX_ENTRIES));
  assign area_we = (cmd_i.act == DP_ACCEPT) && (op_e'(op_i) == OP_APPEND) && !full;
  assign res_we  = (cmd_i.act == DP_DIV_WR);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = AW'(mid_sum[CW:1]);
  // past the end falls back to the last entry
  assign pick    = (lo_q == cnt_q) ? AW'(cnt_q - CW'(1)) : AW'(lo_q);
  assign ge      = (rem_q >= RW'(total_q));
  assign rem_sub = ge ? (rem_q - RW'(total_q)) : rem_q;
  assign run_nx  = run_q + quo_q;

  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.built    = built_q;
  assign sts_o.last     = ((CW'(idx_q) + CW'(1)) == cnt_q);
  assign sts_o.div_last = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
  assign sts_o.div_skip = area_rd_q[AREA_W] || (total_q == '0);
  assign sts_o.found    = (lo_q == hi_q);

  always_ff @(posedge clk_i) begin
    if (area_we) area_mem[AW'(cnt_q)] <= {excluded_i, area_i};
    area_rd_q <= area_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (res_we) prob_mem[idx_q] <= quo_q;
    prob_rd_q <= prob_mem[pick];
  end

  always_ff @(posedge clk_i) begin
    if (res_we) cdf_mem[idx_q] <= run_nx;
    cdf_rd_q <= cdf_mem[mid];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      total_q <= '0;
      built_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      total_q <= total_d;
      built_q <= built_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    run_q      <= run_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dcnt_q     <= dcnt_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    u_q        <= u_d;
    res_st_q   <= res_st_d;
    res_idx_q  <= res_idx_d;
    res_prob_q <= res_prob_d;
    if (cmd_i.load_out) begin
      out_st_q   <= res_st_q;
      out_idx_q  <= res_idx_q;
      out_prob_q <= res_prob_q;
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    total_d    = total_q;
    built_d    = built_q;
    idx_d      = idx_q;
    run_d      = run_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    dcnt_d     = dcnt_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    u_d        = u_q;
    res_st_d   = res_st_q;
    res_idx_d  = res_idx_q;
    res_prob_d = res_prob_q;
    case (cmd_i.act)
      DP_ACCEPT: begin
        res_st_d   = ST_OK;
        res_idx_d  = '0;
        res_prob_d = '0;
        case (op_e'(op_i))
          OP_CLEAR: begin
            cnt_d   = '0;
            total_d = '0;
            built_d = 1'b0;
          end
          OP_APPEND: begin
            if (full) begin
              res_st_d = ST_FULL;
            end else begin
              cnt_d   = cnt_q + CW'(1);
              built_d = 1'b0;
            end
          end
          OP_BUILD: begin
            total_d = '0;
            idx_d   = '0;
            run_d   = '0;
            if (cnt_q == '0) built_d = 1'b1;
          end
          OP_SAMPLE: begin
            u_d  = uniform_fraction_i;
            lo_d = '0;
            hi_d = cnt_q;
            if (cnt_q == '0)  res_st_d = ST_EMPTY;
            else if (!built_q) res_st_d = ST_UNBUILT;
          end
          default: ;
        endcase
      end
      DP_SUM_ACC: begin
        total_d = total_q + TW'(area_rd_q[AREA_W-1:0]);
        idx_d   = sts_o.last ? '0 : idx_q + AW'(1);
      end
      DP_DIV_INIT: begin
        rem_d  = RW'(area_rd_q[AREA_W-1:0]);
        quo_d  = '0;
        dcnt_d = '0;
      end
      DP_DIV_STEP: begin
        rem_d  = rem_sub << 1;
        quo_d  = {quo_q[PROB_W-2:0], ge};
        dcnt_d = dcnt_q + DCNT_W'(1);
      end
      DP_DIV_WR: begin
        run_d = run_nx;
        if (sts_o.last) built_d = 1'b1;
        else            idx_d = idx_q + AW'(1);
      end
      DP_SRCH_CMP: begin
        if (cdf_rd_q > PROB_W'(u_q)) hi_d = CW'(mid);
        else                         lo_d = CW'(mid) + CW'(1);
      end
      DP_PICK: begin
        res_idx_d = pick;
      end
      DP_PICK_OUT: begin
        res_prob_d = prob_rd_q;
      end
      default: ;
    endcase
  end

  assign status_o      = out_st_q;
  assign entry_index_o = ENTRY_IDX_W'(out_idx_q);
  assign probability_o = out_prob_q;

endmodule

FILE: bench/area_weighted_cdf_sampler_unit_tb.sv
`timescale 1ns / 1ps
module area_weighted_cdf_sampler_unit_tb;
  import awcs_pkg::*;

  localparam int NENT      = 1024;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    status_e     st;
    logic [9:0]  idx;
    logic [32:0] prob;
  } draw_res_t;

  class cdf_scoreboard;
    logic [31:0] areas[NENT];
    bit          excl[NENT];
    logic [32:0] prob[NENT];
    logic [32:0] cdf[NENT+1];
    int          count;
    bit          built;
    draw_res_t   pending_q[$];
    int          errors;

    function new();
      count = 0;
      built = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void rebuild();
      logic [41:0] total;
      logic [32:0] run;
      longint unsigned num;
      total = '0;
      run = '0;
      for (int i = 0; i < count; i++) total += areas[i];
      for (int i = 0; i < count; i++) begin
        num = {areas[i], 32'b0};
        prob[i] = (excl[i] || total == 0) ? '0 : 33'(num / longint'(total));
      end
      cdf[0] = '0;
      for (int i = 0; i < count; i++) begin
        run += prob[i];
        cdf[i+1] = run;
      end
      built = 1;
    endfunction

    // Beat accepted on the input side: update the model, queue the result.
    function void note_input(op_e op, logic [31:0] a, bit x, logic [31:0] u);
      draw_res_t r;
      int pick;
      r = '{ST_OK, '0, '0};
      case (op)
        OP_CLEAR: begin
          count = 0;
          built = 0;
        end
        OP_APPEND: begin
          if (count >= NENT) begin
            r.st = ST_FULL;
          end else begin
            areas[count] = a;
            excl[count] = x;
            count++;
            built = 0;
          end
        end
        OP_BUILD: rebuild();
        default: begin
          if (count == 0) begin
            r.st = ST_EMPTY;
          end else if (!built) begin
            r.st = ST_UNBUILT;
          end else begin
            pick = count - 1;
            for (int i = 0; i < count; i++) begin
              if ({1'b0, u} >= cdf[i] && {1'b0, u} < cdf[i+1]) begin
                pick = i;
                break;
              end
            end
            r.idx = 10'(pick);
            r.prob = prob[pick];
          end
        end
      endcase
      pending_q.push_back(r);
    endfunction

    task check(logic [1:0] st, logic [9:0] idx, logic [32:0] p);
      draw_res_t e;
      if (pending_q.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        e = pending_q.pop_front();
        if (st !== e.st) report($sformatf("status %0d exp %0d", st, e.st));
        if (idx !== e.idx) report($sformatf("entry_index %0d exp %0d", idx, e.idx));
        if (p !== e.prob) report($sformatf("probability %h exp %h", p, e.prob));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic [31:0] area_i;
  logic        excluded_i;
  logic [31:0] uniform_fraction_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [9:0]  entry_index_o;
  logic [32:0] probability_o;

  cdf_scoreboard sb;
  int burst_left;
  int idle_cycles;
  int stall_mode;
  int stall_left;

  area_weighted_cdf_sampler_unit u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial sb = new();

  // input and output monitors; both read pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_input(op_e'(operation_i), area_i, excluded_i, uniform_fraction_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check(status_o, entry_index_o, probability_o);
  end

  // receiver stall pattern: free runs, random chatter and long holds
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(5, 60);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= $urandom_range(0, 1);
        default: out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("area_weighted_cdf_sampler_unit_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task send(op_e op, logic [31:0] a = '0, bit x = 0, logic [31:0] u = '0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= op;
    area_i <= a;
    excluded_i <= x;
    uniform_fraction_i <= u;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // step one edge first so the monitor has queued the last accepted beat
  task drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
  endtask

  function automatic logic [31:0] rand_area();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(1, 16);
      3: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_frac();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int n_items;
    int k;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = '0;
    area_i = '0;
    excluded_i = 1'b0;
    uniform_fraction_i = '0;
    burst_left = 0;
    idle_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, unbuilt, all-zero areas, extremes, excluded tail
    send(OP_SAMPLE, '0, 0, 32'h1234);
    send(OP_BUILD);
    send(OP_SAMPLE);
    send(OP_APPEND, '0, 0);
    send(OP_SAMPLE, '0, 0, '1);
    send(OP_BUILD);
    send(OP_SAMPLE, '0, 0, '0);
    send(OP_CLEAR);
    send(OP_APPEND, '1, 0);
    send(OP_APPEND, '1, 1);
    send(OP_APPEND, 32'd1, 0);
    send(OP_BUILD);
    send(OP_SAMPLE, '0, 0, '0);
    send(OP_SAMPLE, '0, 0, '1);
    send(OP_SAMPLE, '0, 0, 32'h7fff_ffff);
    send(OP_SAMPLE, '0, 0, 32'h8000_0000);
    send(OP_APPEND, 32'd5, 1);
    send(OP_BUILD);
    send(OP_SAMPLE, '0, 0, '1);
    send(OP_CLEAR);
    send(OP_SAMPLE, '0, 0, '0);
    drain();

    // fill the table to the brim, then one append too many
    send(OP_CLEAR);
    for (int i = 0; i < NENT; i++) send(OP_APPEND, $urandom_range(0, 1000), $urandom_range(0, 3) == 0);
    send(OP_APPEND, '1, 0);
    send(OP_BUILD);
    repeat (6) send(OP_SAMPLE, '0, 0, rand_frac());
    send(OP_APPEND, 32'd7, 0);
    drain();

    // random: mostly clear/append/build/sample sequences, some noise
    n_items = 0;
    while (n_items < 400) begin
      if ($urandom_range(0, 4) == 0) begin
        send(op_e'($urandom_range(0, 3)), rand_area(), $urandom_range(0, 1), rand_frac());
        n_items++;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          send(OP_CLEAR);
          n_items++;
        end
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        for (int i = 0; i < k; i++) send(OP_APPEND, rand_area(), $urandom_range(0, 3) == 0);
        n_items += k;
        if ($urandom_range(0, 5) == 0) begin
          send(OP_SAMPLE, '0, 0, rand_frac());
          n_items++;
        end
        send(OP_BUILD);
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) send(OP_SAMPLE, '0, 0, rand_frac());
        n_items += k + 1;
      end
      if ($urandom_range(0, 15) == 0) drain();
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("area_weighted_cdf_sampler_unit_tb: PASS");
    end else begin
      $display("area_weighted_cdf_sampler_unit_tb: FAIL");
    end
    $finish;
  end
endmodule
